/* sv/shtst_pkg.sv */
// Shared types, codes and defaults for the stroke hit tester.
package shtst_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam logic [11:0] STROKE_WIDTH_RESET = 12'd480;

   // Action codes on the request channel
   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   // Status codes on the response channel
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_REMOVE,
      OP_QUERY,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEG_RD,
      ST_SEG_A,
      ST_SEG_B,
      ST_SEG_C,
      ST_SEG_D,
      ST_SEG_E,
      ST_VTX_RD,
      ST_VTX_A,
      ST_VTX_B,
      ST_VTX_C,
      ST_ROOT,
      ST_DONE
   } back_state_type;

endpackage

/* sv/shtst_front.sv */
// Front end: accepts request transfers and classifies the action code.
module shtst_front (
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_action,
   input  logic signed [15:0]         req_x_coord,
   input  logic signed [15:0]         req_y_coord,
   input  shtst_pkg::fifo_status_type fifo_status,
   output logic                       push,
   output shtst_pkg::item_type        push_item
);

   // Stall while the queue is full
   assign req_stall = fifo_status.full;
   assign push      = req_valid && !fifo_status.full;

   // Decode the action into an operation
   always_comb begin
      push_item.x = req_x_coord;
      push_item.y = req_y_coord;
      case (req_action)
         shtst_pkg::ACT_APPEND: push_item.op = shtst_pkg::OP_APPEND;
         shtst_pkg::ACT_REMOVE: push_item.op = shtst_pkg::OP_REMOVE;
         shtst_pkg::ACT_QUERY:  push_item.op = shtst_pkg::OP_QUERY;
         default:               push_item.op = shtst_pkg::OP_NONE;
      endcase
   end

endmodule

/* sv/shtst_fifo.sv */
// Two-entry queue between the front end and the execution engine.
module shtst_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  shtst_pkg::item_type        push_item,
   input  logic                       pop,
   output shtst_pkg::item_type        head_item,
   output shtst_pkg::fifo_status_type status
);

   shtst_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entry_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == 2'd2);
   assign status.empty = (fill_ff == 2'd0);

endmodule

/* sv/shtst_back.sv */
// Execution engine: vertex store, segment and vertex tests, root unit, output register.
module shtst_back #(
   parameter int MAX_VERTICES = shtst_pkg::MAX_VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [11:0]         stroke_width,
   input  shtst_pkg::item_type head_item,
   input  logic                fifo_empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [11:0]         rsp_distance,
   output logic [6:0]          rsp_vertex_count,
   output logic [1:0]          rsp_status
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_VERTICES);

   // Vertex store
   logic signed [15:0] vx_mem [MAX_VERTICES];
   logic signed [15:0] vy_mem [MAX_VERTICES];
   logic signed [15:0] rd_x_ff, rd_y_ff;
   logic               mem_wr;
   logic [AW-1:0]      rd_addr;

   shtst_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      j_ff, j_in;
   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in, ax_ff, ax_in, ay_ff, ay_in;
   logic signed [33:0] pxx_ff, pyy_ff, pad_ff, pbd_ff, pac_ff, pbc_ff;
   logic signed [33:0] pxx_in, pyy_in, pad_in, pbd_in, pac_in, pbc_in;
   logic signed [34:0] l2_s, dot_s, cross_s, d2_s;
   logic [34:0]        ac_abs;
   logic [33:0]        l2_ff, l2_in;
   logic [28:0]        ac_ff, ac_in;
   logic [57:0]        c2_ff, c2_in;
   logic [41:0]        wl_lo_ff, wl_lo_in;
   logic [39:0]        wl_hi_ff, wl_hi_in;
   logic [57:0]        wl_sum;
   logic [23:0]        w2_ff;
   logic [57:0]        n_ff, n_in;
   logic [33:0]        m_ff, m_in;
   logic [63:0]        s_ff, s_in, p_ff, p_in, cand, m64;
   logic [11:0]        q_ff, q_in;
   logic [3:0]         b_ff, b_in;
   logic               res_hit_ff, res_hit_in;
   logic [11:0]        res_dist_ff, res_dist_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               out_free, out_load;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [11:0]        rsp_distance_ff;
   logic [6:0]         rsp_vertex_count_ff;
   logic [1:0]         rsp_status_ff;

   assign rd_addr  = j_ff[AW-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Band and vertex arithmetic shared by the sequencer
   always_comb begin
      l2_s    = 35'(pxx_ff) + 35'(pyy_ff);
      dot_s   = 35'(pad_ff) + 35'(pbd_ff);
      cross_s = 35'(pac_ff) - 35'(pbc_ff);
      d2_s    = l2_s;
      ac_abs  = cross_s[34] ? 35'(-cross_s) : 35'(cross_s);
      wl_sum  = 58'(wl_lo_ff) + {wl_hi_ff, 18'd0};
      m64     = 64'(m_ff);
      cand    = s_ff + (p_ff << (5'(b_ff) + 5'd1)) + (m64 << {b_ff, 1'b0});
   end

   // Sequence one item through the store, the tests and the root unit
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      j_in          = j_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      pxx_in        = dx_ff * dx_ff;
      pyy_in        = dy_ff * dy_ff;
      pad_in        = ax_ff * dx_ff;
      pbd_in        = ay_ff * dy_ff;
      pac_in        = ax_ff * dy_ff;
      pbc_in        = dx_ff * ay_ff;
      l2_in         = l2_ff;
      ac_in         = ac_ff;
      c2_in         = 58'(ac_ff) * 58'(ac_ff);
      wl_lo_in      = 42'(w2_ff) * 42'(l2_ff[17:0]);
      wl_hi_in      = 40'(w2_ff) * 40'(l2_ff[33:18]);
      n_in          = n_ff;
      m_in          = m_ff;
      s_in          = s_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      b_in          = b_ff;
      res_hit_in    = res_hit_ff;
      res_dist_in   = res_dist_ff;
      res_status_in = res_status_ff;
      pop           = 1'b0;
      mem_wr        = 1'b0;
      out_load      = 1'b0;

      case (state_ff)
         shtst_pkg::ST_IDLE: begin
            if (!fifo_empty) begin
               pop           = 1'b1;
               qx_in         = head_item.x;
               qy_in         = head_item.y;
               j_in          = '0;
               res_hit_in    = 1'b0;
               res_dist_in   = '0;
               res_status_in = shtst_pkg::STATUS_OK;
               state_in      = shtst_pkg::ST_DONE;
               case (head_item.op)
                  shtst_pkg::OP_APPEND: begin
                     if (count_ff < MAX_COUNT) begin
                        mem_wr   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        res_status_in = shtst_pkg::STATUS_FULL;
                     end
                  end
                  shtst_pkg::OP_REMOVE: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        res_status_in = shtst_pkg::STATUS_EMPTY;
                     end
                  end
                  shtst_pkg::OP_QUERY: begin
                     if (count_ff != '0) begin
                        state_in = shtst_pkg::ST_SEG_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         shtst_pkg::ST_SEG_RD: state_in = shtst_pkg::ST_SEG_A;
         shtst_pkg::ST_SEG_A: begin
            // Form segment and point offsets, then shift the current vertex in
            dx_in     = 17'(rd_x_ff) - 17'(prev_x_ff);
            dy_in     = 17'(rd_y_ff) - 17'(prev_y_ff);
            ax_in     = 17'(qx_ff) - 17'(prev_x_ff);
            ay_in     = 17'(qy_ff) - 17'(prev_y_ff);
            prev_x_in = rd_x_ff;
            prev_y_in = rd_y_ff;
            if (j_ff == '0) begin
               if (count_ff > CW'(1)) begin
                  j_in     = j_ff + 1'b1;
                  state_in = shtst_pkg::ST_SEG_RD;
               end else begin
                  state_in = shtst_pkg::ST_VTX_RD;
               end
            end else begin
               state_in = shtst_pkg::ST_SEG_B;
            end
         end
         shtst_pkg::ST_SEG_B: state_in = shtst_pkg::ST_SEG_C;
         shtst_pkg::ST_SEG_C: begin
            // Drop zero-length segments, points outside the segment ends and cross products too wide to square
            l2_in = l2_s[33:0];
            ac_in = ac_abs[28:0];
            if (l2_s == '0 || dot_s < 0 || dot_s > l2_s || ac_abs[34:29] != '0) begin
               if (j_ff + 1'b1 < count_ff) begin
                  j_in     = j_ff + 1'b1;
                  state_in = shtst_pkg::ST_SEG_RD;
               end else begin
                  j_in     = '0;
                  state_in = shtst_pkg::ST_VTX_RD;
               end
            end else begin
               state_in = shtst_pkg::ST_SEG_D;
            end
         end
         shtst_pkg::ST_SEG_D: state_in = shtst_pkg::ST_SEG_E;
         shtst_pkg::ST_SEG_E: begin
            if (c2_ff < wl_sum) begin
               n_in     = c2_ff;
               m_in     = l2_ff;
               s_in     = '0;
               p_in     = '0;
               q_in     = '0;
               b_in     = 4'd11;
               state_in = shtst_pkg::ST_ROOT;
            end else if (j_ff + 1'b1 < count_ff) begin
               j_in     = j_ff + 1'b1;
               state_in = shtst_pkg::ST_SEG_RD;
            end else begin
               j_in     = '0;
               state_in = shtst_pkg::ST_VTX_RD;
            end
         end
         shtst_pkg::ST_VTX_RD: state_in = shtst_pkg::ST_VTX_A;
         shtst_pkg::ST_VTX_A: begin
            dx_in    = 17'(rd_x_ff) - 17'(qx_ff);
            dy_in    = 17'(rd_y_ff) - 17'(qy_ff);
            state_in = shtst_pkg::ST_VTX_B;
         end
         shtst_pkg::ST_VTX_B: state_in = shtst_pkg::ST_VTX_C;
         shtst_pkg::ST_VTX_C: begin
            if (d2_s < 35'(w2_ff)) begin
               n_in     = 58'(d2_s);
               m_in     = 34'd1;
               s_in     = '0;
               p_in     = '0;
               q_in     = '0;
               b_in     = 4'd11;
               state_in = shtst_pkg::ST_ROOT;
            end else if (j_ff + 1'b1 < count_ff) begin
               j_in     = j_ff + 1'b1;
               state_in = shtst_pkg::ST_VTX_RD;
            end else begin
               state_in = shtst_pkg::ST_DONE;
            end
         end
         shtst_pkg::ST_ROOT: begin
            // One quotient bit a cycle: keep q*q*m and q*m as running sums
            if (cand <= 64'(n_ff)) begin
               q_in = q_ff | (12'd1 << b_ff);
               s_in = cand;
               p_in = p_ff + (m64 << b_ff);
            end
            if (b_ff == 4'd0) begin
               res_hit_in  = 1'b1;
               res_dist_in = q_in;
               state_in    = shtst_pkg::ST_DONE;
            end else begin
               b_in = b_ff - 4'd1;
            end
         end
         shtst_pkg::ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = shtst_pkg::ST_IDLE;
            end
         end
         default: state_in = shtst_pkg::ST_IDLE;
      endcase
   end

   // Hold the response until it is taken
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shtst_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      pxx_ff        <= pxx_in;
      pyy_ff        <= pyy_in;
      pad_ff        <= pad_in;
      pbd_ff        <= pbd_in;
      pac_ff        <= pac_in;
      pbc_ff        <= pbc_in;
      l2_ff         <= l2_in;
      ac_ff         <= ac_in;
      c2_ff         <= c2_in;
      wl_lo_ff      <= wl_lo_in;
      wl_hi_ff      <= wl_hi_in;
      w2_ff         <= 24'(stroke_width) * 24'(stroke_width);
      n_ff          <= n_in;
      m_ff          <= m_in;
      s_ff          <= s_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      b_ff          <= b_in;
      res_hit_ff    <= res_hit_in;
      res_dist_ff   <= res_dist_in;
      res_status_ff <= res_status_in;
      if (out_load) begin
         rsp_hit_ff          <= res_hit_ff;
         rsp_distance_ff     <= res_dist_ff;
         rsp_vertex_count_ff <= 7'(count_ff);
         rsp_status_ff       <= res_status_ff;
      end
   end

   // Write the appended vertex, read one vertex a cycle
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         vx_mem[count_ff[AW-1:0]] <= head_item.x;
         vy_mem[count_ff[AW-1:0]] <= head_item.y;
      end
      rd_x_ff <= vx_mem[rd_addr];
      rd_y_ff <= vy_mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_distance     = rsp_distance_ff;
   assign rsp_vertex_count = rsp_vertex_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* sv/stroke_hit_test_top.sv */
// Stroke hit tester top level: front end, item queue and execution engine.
// An append or remove is queued, taken from the queue in the idle state and answered from
// the done state through the output register. A query walks the segments, each in up to
// six states (a read, an offset stage, a multiply stage, a sum and window check, a
// squaring stage, then the band compare), then the vertices, each in four states (a read,
// an offset stage, a squaring stage, then the band compare), and ends in a 12-bit
// bit-serial square root when something is hit. The single read port of the vertex store
// sets the walk. Two more items queue up behind a running query.
module stroke_hit_test_top #(
   parameter int MAX_VERTICES = shtst_pkg::MAX_VERTICES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [11:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_x_coord,
   input  logic signed [15:0] req_y_coord,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [11:0]        rsp_distance,
   output logic [6:0]         rsp_vertex_count,
   output logic [1:0]         rsp_status
);

   logic [11:0]                stroke_width_ff;
   logic                       push, pop;
   shtst_pkg::item_type        push_item, head_item;
   shtst_pkg::fifo_status_type fifo_status;

   // Hold the band half-width
   always_ff @(posedge clock) begin
      if (reset) begin
         stroke_width_ff <= shtst_pkg::STROKE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         stroke_width_ff <= csr_wr_data;
      end
   end

   shtst_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .fifo_status (fifo_status),
      .push        (push),
      .push_item   (push_item)
   );

   shtst_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (fifo_status)
   );

   shtst_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .stroke_width     (stroke_width_ff),
      .head_item        (head_item),
      .fifo_empty       (fifo_status.empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_distance     (rsp_distance),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_status       (rsp_status)
   );

endmodule

/* sv/shtst_checker.sv */
// Port-level checks for the stroke hit tester, bound to the top level.
module shtst_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [11:0] rsp_distance,
   input logic [1:0]  rsp_status
);

   // A stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A miss reports no distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_distance == 12'd0)
      else $error("miss with nonzero distance");

   // Only a query can hit, and a query always reports ok
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_status == shtst_pkg::STATUS_OK)
      else $error("hit with error status");

   // No response right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind stroke_hit_test_top shtst_checker u_checker (.*);
